>>> rtl/core/deo_pkg.sv
// Shared constants, codes and types of the dependency execution order block.
package deo_pkg;
	localparam int NODES  = 64;
	localparam int PINS   = 8;
	localparam int NODE_W = $clog2(NODES);
	localparam int PIN_W  = $clog2(PINS);
	localparam int CNT_W  = $clog2(PINS + 1);
	localparam int IDX_W  = $clog2(NODES + 1);
	localparam int CMD_W  = 3;
	localparam int ST_W   = 2;

	localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd0;
	localparam logic [CMD_W-1:0] CMD_SET_COUNT  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_CONNECT    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DISCONNECT = 3'd3;
	localparam logic [CMD_W-1:0] CMD_RUN        = 3'd4;

	localparam logic [ST_W-1:0] ST_OK         = 2'd0;
	localparam logic [ST_W-1:0] ST_INCOMPLETE = 2'd1;
	localparam logic [ST_W-1:0] ST_CYCLE      = 2'd2;

	typedef struct packed {
		logic [CNT_W-1:0]              total;
		logic [PINS-1:0]               linked;
		logic [PINS-1:0][NODE_W-1:0]   src;
	} row_t;
endpackage

>>> rtl/core/deo_if.sv
// Request and result channel interfaces.
interface deo_req_if;
	logic                        valid;
	logic                        ready;
	logic [deo_pkg::CMD_W-1:0]   cmd;
	logic [deo_pkg::NODE_W-1:0]  node;
	logic [deo_pkg::PIN_W-1:0]   pin;
	logic [deo_pkg::NODE_W-1:0]  source_node;
	logic [deo_pkg::CNT_W-1:0]   input_count;
	modport source (output valid, cmd, node, pin, source_node, input_count, input ready);
	modport sink (input valid, cmd, node, pin, source_node, input_count, output ready);
endinterface

interface deo_res_if;
	logic                        valid;
	logic                        ready;
	logic [deo_pkg::NODE_W-1:0]  order_node;
	logic [deo_pkg::ST_W-1:0]    status;
	logic                        last;
	modport source (output valid, order_node, status, last, input ready);
	modport sink (input valid, order_node, status, last, output ready);
endinterface

>>> rtl/core/deo_ram.sv
// Generic single-write, single-read RAM with registered read data.
module deo_ram #(
	parameter int Width = 8,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(Depth)-1:0] wr_addr,
	input  logic [Width-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(Depth)-1:0] rd_addr,
	output logic [Width-1:0]         rd_data
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

>>> rtl/core/dependency_execution_order.sv
// Top level: graph store, ancestor walk and Kahn ordering sequencer.
// Load words either clear in decode or read-modify-write one graph row.
// A run pops each ancestor, reads its row and checks one pin at a time for the walk,
// reads and checks every node's row to seed the queue, then per emitted node pops it
// and scans rows, all through the single graph row RAM port; results wait for ready.
// Reset clears all link and count state at once through per-row valid flags.
module dependency_execution_order (
	input logic     clk,
	input logic     arst_n,
	deo_req_if.sink req,
	deo_res_if.source res
);
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DECODE = 4'd1;
	localparam logic [3:0] S_LD_WR  = 4'd2;
	localparam logic [3:0] S_W_POP  = 4'd3;
	localparam logic [3:0] S_W_POPD = 4'd4;
	localparam logic [3:0] S_W_PIN  = 4'd5;
	localparam logic [3:0] S_KI_RD  = 4'd6;
	localparam logic [3:0] S_KI_CHK = 4'd7;
	localparam logic [3:0] S_K_POP  = 4'd8;
	localparam logic [3:0] S_K_CUR  = 4'd9;
	localparam logic [3:0] S_KS_RD  = 4'd10;
	localparam logic [3:0] S_KS_UPD = 4'd11;
	localparam logic [3:0] S_O_RD   = 4'd12;
	localparam logic [3:0] S_O_LD   = 4'd13;
	localparam logic [3:0] S_O_WAIT = 4'd14;

	localparam int RowW = $bits(deo_pkg::row_t);

	logic [3:0]                  state_q;
	logic [deo_pkg::CMD_W-1:0]   cmd_q;
	logic [deo_pkg::NODE_W-1:0]  node_q;
	logic [deo_pkg::PIN_W-1:0]   pin_q;
	logic [deo_pkg::NODE_W-1:0]  src_q;
	logic [deo_pkg::CNT_W-1:0]   cnt_q;
	logic [deo_pkg::NODES-1:0]   vld_q;
	logic [deo_pkg::NODES-1:0]   mark_q;
	logic [deo_pkg::IDX_W-1:0]   sp_q;
	logic [deo_pkg::IDX_W-1:0]   members_q;
	logic [deo_pkg::IDX_W-1:0]   head_q;
	logic [deo_pkg::IDX_W-1:0]   tail_q;
	logic [deo_pkg::IDX_W-1:0]   v_q;
	logic [deo_pkg::CNT_W-1:0]   p_q;
	logic                        inc_q;
	logic [deo_pkg::NODE_W-1:0]  cur_q;
	logic [deo_pkg::NODE_W-1:0]  g_raddr_q;
	logic                        ovld_q;
	logic [deo_pkg::NODE_W-1:0]  onode_q;
	logic [deo_pkg::ST_W-1:0]    ost_q;
	logic                        olast_q;

	logic                        g_we, g_re;
	logic [deo_pkg::NODE_W-1:0]  g_waddr, g_raddr;
	logic [RowW-1:0]             g_rd;
	deo_pkg::row_t               row_eff, row_mod;
	logic                        s_we, s_re;
	logic [deo_pkg::NODE_W-1:0]  s_waddr, s_raddr, s_wdata, s_rd;
	logic                        p_we, p_re;
	logic [deo_pkg::NODE_W-1:0]  p_addr;
	logic [deo_pkg::CNT_W-1:0]   p_wdata, p_rd;
	logic                        q_we, q_re;
	logic [deo_pkg::NODE_W-1:0]  q_waddr, q_raddr, q_wdata, q_rd;

	logic [deo_pkg::NODE_W-1:0]  v_idx;
	logic                        pin_live, pin_linked, push;
	logic [deo_pkg::NODE_W-1:0]  pin_src;
	logic [deo_pkg::CNT_W-1:0]   mcnt, newp;
	logic                        upd, newzero;

	assign req.ready = (state_q == S_IDLE);
	assign res.valid = ovld_q;
	assign res.order_node = onode_q;
	assign res.status = ost_q;
	assign res.last = olast_q;

	assign v_idx = v_q[deo_pkg::NODE_W-1:0];
	assign row_eff = vld_q[g_raddr_q] ? deo_pkg::row_t'(g_rd) : '0;
	assign pin_live = (p_q < row_eff.total);
	assign pin_linked = row_eff.linked[p_q[deo_pkg::PIN_W-1:0]];
	assign pin_src = row_eff.src[p_q[deo_pkg::PIN_W-1:0]];
	assign push = (state_q == S_W_PIN) && pin_live && pin_linked && !mark_q[pin_src];

	always_comb begin
		mcnt = '0;
		for (int j = 0; j < deo_pkg::PINS; j++) begin
			if ((deo_pkg::CNT_W'(j) < row_eff.total) && row_eff.linked[j]
			    && (row_eff.src[j] == cur_q)) begin
				mcnt = mcnt + deo_pkg::CNT_W'(1);
			end
		end
		upd = (p_rd != '0) && (mcnt != '0);
		newp = (mcnt >= p_rd) ? '0 : p_rd - mcnt;
		newzero = upd && (newp == '0);
	end

	always_comb begin
		row_mod = row_eff;
		case (cmd_q)
			deo_pkg::CMD_SET_COUNT: begin
				row_mod.total = (cnt_q > deo_pkg::CNT_W'(deo_pkg::PINS))
				                ? deo_pkg::CNT_W'(deo_pkg::PINS) : cnt_q;
			end
			deo_pkg::CMD_CONNECT: begin
				if (!row_eff.linked[pin_q]) begin
					row_mod.linked[pin_q] = 1'b1;
					row_mod.src[pin_q] = src_q;
				end
			end
			deo_pkg::CMD_DISCONNECT: begin
				row_mod.linked[pin_q] = 1'b0;
			end
			default: begin
				row_mod = row_eff;
			end
		endcase
	end

	always_comb begin
		g_we = 1'b0; g_waddr = node_q;
		g_re = 1'b0; g_raddr = node_q;
		s_we = 1'b0; s_waddr = sp_q[deo_pkg::NODE_W-1:0]; s_wdata = pin_src;
		s_re = 1'b0; s_raddr = sp_q[deo_pkg::NODE_W-1:0] - deo_pkg::NODE_W'(1);
		p_we = 1'b0; p_re = 1'b0; p_addr = v_idx; p_wdata = newp;
		q_we = 1'b0; q_waddr = tail_q[deo_pkg::NODE_W-1:0]; q_wdata = v_idx;
		q_re = 1'b0; q_raddr = head_q[deo_pkg::NODE_W-1:0];
		case (state_q)
			S_DECODE: begin
				if (cmd_q == deo_pkg::CMD_SET_COUNT || cmd_q == deo_pkg::CMD_CONNECT
				    || cmd_q == deo_pkg::CMD_DISCONNECT) begin
					g_re = 1'b1;
				end
				if (cmd_q == deo_pkg::CMD_RUN) begin
					s_we = 1'b1;
					s_waddr = '0;
					s_wdata = node_q;
				end
			end
			S_LD_WR: g_we = 1'b1;
			S_W_POP: s_re = (sp_q != '0);
			S_W_POPD: begin
				g_re = 1'b1;
				g_raddr = s_rd;
			end
			S_W_PIN: s_we = push;
			S_KI_RD: begin
				g_re = (v_q != deo_pkg::IDX_W'(deo_pkg::NODES));
				g_raddr = v_idx;
			end
			S_KI_CHK: begin
				p_we = mark_q[v_idx];
				p_wdata = row_eff.total;
				q_we = mark_q[v_idx] && (row_eff.total == '0);
			end
			S_K_POP: q_re = (head_q != tail_q);
			S_KS_RD: begin
				g_re = (v_q != deo_pkg::IDX_W'(deo_pkg::NODES)) && mark_q[v_idx];
				g_raddr = v_idx;
				p_re = g_re;
			end
			S_KS_UPD: begin
				p_we = upd;
				q_we = newzero;
			end
			S_O_RD: q_re = 1'b1;
			default: begin
				g_we = 1'b0;
			end
		endcase
	end

	deo_ram #(.Width(RowW), .Depth(deo_pkg::NODES)) u_graph (
		.clk(clk), .wr_en(g_we), .wr_addr(g_waddr), .wr_data(RowW'(row_mod)),
		.rd_en(g_re), .rd_addr(g_raddr), .rd_data(g_rd)
	);
	deo_ram #(.Width(deo_pkg::NODE_W), .Depth(deo_pkg::NODES)) u_stack (
		.clk(clk), .wr_en(s_we), .wr_addr(s_waddr), .wr_data(s_wdata),
		.rd_en(s_re), .rd_addr(s_raddr), .rd_data(s_rd)
	);
	deo_ram #(.Width(deo_pkg::CNT_W), .Depth(deo_pkg::NODES)) u_pending (
		.clk(clk), .wr_en(p_we), .wr_addr(p_addr), .wr_data(p_wdata),
		.rd_en(p_re), .rd_addr(p_addr), .rd_data(p_rd)
	);
	deo_ram #(.Width(deo_pkg::NODE_W), .Depth(deo_pkg::NODES)) u_queue (
		.clk(clk), .wr_en(q_we), .wr_addr(q_waddr), .wr_data(q_wdata),
		.rd_en(q_re), .rd_addr(q_raddr), .rd_data(q_rd)
	);

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cmd_q <= req.cmd;
			node_q <= req.node;
			pin_q <= req.pin;
			src_q <= req.source_node;
			cnt_q <= req.input_count;
		end
		if (g_re) begin
			g_raddr_q <= g_raddr;
		end
		if (state_q == S_K_CUR) begin
			cur_q <= q_rd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			vld_q <= '0;
			mark_q <= '0;
			sp_q <= '0;
			members_q <= '0;
			head_q <= '0;
			tail_q <= '0;
			v_q <= '0;
			p_q <= '0;
			inc_q <= 1'b0;
			ovld_q <= 1'b0;
			onode_q <= '0;
			ost_q <= deo_pkg::ST_OK;
			olast_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					case (cmd_q)
						deo_pkg::CMD_CLEAR: begin
							vld_q <= '0;
							state_q <= S_IDLE;
						end
						deo_pkg::CMD_SET_COUNT, deo_pkg::CMD_CONNECT,
						deo_pkg::CMD_DISCONNECT: begin
							state_q <= S_LD_WR;
						end
						deo_pkg::CMD_RUN: begin
							mark_q <= deo_pkg::NODES'(1) << node_q;
							sp_q <= deo_pkg::IDX_W'(1);
							members_q <= deo_pkg::IDX_W'(1);
							inc_q <= 1'b0;
							state_q <= S_W_POP;
						end
						default: begin
							state_q <= S_IDLE;
						end
					endcase
				end
				S_LD_WR: begin
					vld_q[node_q] <= 1'b1;
					state_q <= S_IDLE;
				end
				S_W_POP: begin
					if (sp_q != '0) begin
						sp_q <= sp_q - deo_pkg::IDX_W'(1);
						state_q <= S_W_POPD;
					end else if (inc_q) begin
						ovld_q <= 1'b1;
						onode_q <= '0;
						ost_q <= deo_pkg::ST_INCOMPLETE;
						olast_q <= 1'b1;
						state_q <= S_O_WAIT;
					end else begin
						v_q <= '0;
						tail_q <= '0;
						head_q <= '0;
						state_q <= S_KI_RD;
					end
				end
				S_W_POPD: begin
					p_q <= '0;
					state_q <= S_W_PIN;
				end
				S_W_PIN: begin
					if (!pin_live) begin
						state_q <= S_W_POP;
					end else begin
						if (!pin_linked) begin
							inc_q <= 1'b1;
						end
						if (push) begin
							mark_q[pin_src] <= 1'b1;
							sp_q <= sp_q + deo_pkg::IDX_W'(1);
							members_q <= members_q + deo_pkg::IDX_W'(1);
						end
						p_q <= p_q + deo_pkg::CNT_W'(1);
					end
				end
				S_KI_RD: begin
					state_q <= (v_q == deo_pkg::IDX_W'(deo_pkg::NODES)) ? S_K_POP : S_KI_CHK;
				end
				S_KI_CHK: begin
					if (q_we) begin
						tail_q <= tail_q + deo_pkg::IDX_W'(1);
					end
					v_q <= v_q + deo_pkg::IDX_W'(1);
					state_q <= S_KI_RD;
				end
				S_K_POP: begin
					if (head_q != tail_q) begin
						head_q <= head_q + deo_pkg::IDX_W'(1);
						state_q <= S_K_CUR;
					end else if (tail_q != members_q) begin
						ovld_q <= 1'b1;
						onode_q <= '0;
						ost_q <= deo_pkg::ST_CYCLE;
						olast_q <= 1'b1;
						state_q <= S_O_WAIT;
					end else begin
						head_q <= '0;
						state_q <= S_O_RD;
					end
				end
				S_K_CUR: begin
					v_q <= '0;
					state_q <= S_KS_RD;
				end
				S_KS_RD: begin
					if (v_q == deo_pkg::IDX_W'(deo_pkg::NODES)) begin
						state_q <= S_K_POP;
					end else if (mark_q[v_idx]) begin
						state_q <= S_KS_UPD;
					end else begin
						v_q <= v_q + deo_pkg::IDX_W'(1);
					end
				end
				S_KS_UPD: begin
					if (newzero) begin
						tail_q <= tail_q + deo_pkg::IDX_W'(1);
					end
					v_q <= v_q + deo_pkg::IDX_W'(1);
					state_q <= S_KS_RD;
				end
				S_O_RD: begin
					state_q <= S_O_LD;
				end
				S_O_LD: begin
					ovld_q <= 1'b1;
					onode_q <= q_rd;
					ost_q <= deo_pkg::ST_OK;
					olast_q <= ((head_q + deo_pkg::IDX_W'(1)) == tail_q);
					head_q <= head_q + deo_pkg::IDX_W'(1);
					state_q <= S_O_WAIT;
				end
				S_O_WAIT: begin
					if (res.ready) begin
						ovld_q <= 1'b0;
						state_q <= olast_q ? S_IDLE : S_O_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

>>> rtl/core/deo_checker.sv
// Port-level checker for the dependency execution order block, with its bind.
module deo_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_ready,
	input logic                        res_valid,
	input logic                        res_ready,
	input logic [deo_pkg::NODE_W-1:0]  order_node,
	input logic [deo_pkg::ST_W-1:0]    status,
	input logic                        last
);
	a_busy_while_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !req_ready)
		else $error("request ready while a result word is pending");

	a_accept_drops_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("ready held after accepting a word");

	a_error_single: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && status != deo_pkg::ST_OK) |-> (last && order_node == '0))
		else $error("error status word not final or node not zero");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(order_node)
		&& $stable(status) && $stable(last)))
		else $error("stalled result word changed");
endmodule

bind dependency_execution_order deo_checker u_deo_checker (
	.clk(clk),
	.arst_n(arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.res_valid(res.valid),
	.res_ready(res.ready),
	.order_node(res.order_node),
	.status(res.status),
	.last(res.last)
);

>>> dv/tb_top.sv
// Self-checking testbench of dependency_execution_order: random graphs, runs and order check.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG = 200000;
	localparam int DRAIN    = 400;
	localparam logic [deo_pkg::CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
	localparam logic [deo_pkg::CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

	typedef struct {
		logic [deo_pkg::CMD_W-1:0]  cmd;
		logic [deo_pkg::NODE_W-1:0] node;
		logic [deo_pkg::PIN_W-1:0]  pin;
		logic [deo_pkg::NODE_W-1:0] source_node;
		logic [deo_pkg::CNT_W-1:0]  input_count;
	} word_t;

	typedef struct {
		logic [deo_pkg::NODE_W-1:0] order_node;
		logic [deo_pkg::ST_W-1:0]   status;
		logic                       last;
	} step_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	deo_req_if req();
	deo_res_if res();

	dependency_execution_order i_dut (.clk(clk), .arst_n(arst_n), .req(req), .res(res));

	always #5 clk = ~clk;

	word_t words[$];
	step_t order_exp[$];
	int    errors = 0;
	int    cyc = 0;
	int    idle_cycles = 0;
	bit    hold_res = 1'b0;
	bit    quiet;

	// graph copy
	logic [deo_pkg::CNT_W-1:0]  g_total[deo_pkg::NODES];
	logic [deo_pkg::NODE_W-1:0] g_src[deo_pkg::NODES*deo_pkg::PINS];
	bit                         g_linked[deo_pkg::NODES*deo_pkg::PINS];

	assign quiet = (cyc >= 3000) && (cyc < 6000);

	task automatic report(input string what);
		errors++;
		$display("%0t mismatch: %s", $realtime, what);
	endtask

	function automatic void push_status(input logic [deo_pkg::ST_W-1:0] st);
		step_t e;
		e.order_node = '0;
		e.status     = st;
		e.last       = 1'b1;
		order_exp.insert(order_exp.size(), e);
	endfunction

	function automatic void predict_order(input int target);
		bit mark[deo_pkg::NODES];
		int pend[deo_pkg::NODES];
		int stack[$];
		int rdy[$];
		int emitted[$];
		int members;
		int v;
		int cur;
		int slot;
		bit incomplete;
		step_t e;
		members = 1;
		incomplete = 0;
		foreach (mark[i]) begin
			mark[i] = 0;
			pend[i] = 0;
		end
		mark[target] = 1;
		stack.insert(stack.size(), target);
		while (stack.size() > 0) begin
			v = stack[stack.size() - 1];
			stack.delete(stack.size() - 1);
			for (int p = 0; p < g_total[v]; p++) begin
				slot = v * deo_pkg::PINS + p;
				if (!g_linked[slot]) begin
					incomplete = 1;
				end else if (!mark[g_src[slot]]) begin
					mark[g_src[slot]] = 1;
					stack.insert(stack.size(), int'(g_src[slot]));
					members++;
				end
			end
		end
		if (incomplete) begin
			push_status(deo_pkg::ST_INCOMPLETE);
			return;
		end
		for (int n = 0; n < deo_pkg::NODES; n++) begin
			if (mark[n]) begin
				pend[n] = g_total[n];
				if (pend[n] == 0) rdy.insert(rdy.size(), n);
			end
		end
		while (rdy.size() > 0) begin
			cur = rdy.pop_front();
			emitted.insert(emitted.size(), cur);
			for (int n = 0; n < deo_pkg::NODES; n++) begin
				if (mark[n]) begin
					for (int p = 0; p < g_total[n]; p++) begin
						slot = n * deo_pkg::PINS + p;
						if (g_linked[slot] && g_src[slot] == cur && pend[n] > 0) begin
							pend[n]--;
							if (pend[n] == 0) rdy.insert(rdy.size(), n);
						end
					end
				end
			end
		end
		if (emitted.size() < members) begin
			push_status(deo_pkg::ST_CYCLE);
			return;
		end
		foreach (emitted[i]) begin
			e.order_node = deo_pkg::NODE_W'(emitted[i]);
			e.status     = deo_pkg::ST_OK;
			e.last       = (i == emitted.size() - 1);
			order_exp.insert(order_exp.size(), e);
		end
	endfunction

	function automatic void apply_word(input word_t w);
		int slot;
		slot = w.node * deo_pkg::PINS + w.pin;
		case (w.cmd)
			deo_pkg::CMD_CLEAR: begin
				foreach (g_total[i]) g_total[i] = '0;
				foreach (g_linked[i]) g_linked[i] = 0;
			end
			deo_pkg::CMD_SET_COUNT: begin
				g_total[w.node] = (w.input_count > deo_pkg::PINS)
				                  ? deo_pkg::CNT_W'(deo_pkg::PINS) : w.input_count;
			end
			deo_pkg::CMD_CONNECT: begin
				if (!g_linked[slot]) begin
					g_linked[slot] = 1;
					g_src[slot] = w.source_node;
				end
			end
			deo_pkg::CMD_DISCONNECT: begin
				g_linked[slot] = 0;
			end
			deo_pkg::CMD_RUN: begin
				predict_order(w.node);
			end
			default: ;
		endcase
	endfunction

	function automatic void add(input logic [deo_pkg::CMD_W-1:0] c, input int n,
			input int p = 0, input int s = 0, input int k = 0);
		word_t w;
		w.cmd = c;
		w.node = deo_pkg::NODE_W'(n);
		w.pin = deo_pkg::PIN_W'(p);
		w.source_node = deo_pkg::NODE_W'(s);
		w.input_count = deo_pkg::CNT_W'(k);
		words.insert(words.size(), w);
	endfunction

	function automatic void add_noise();
		word_t w;
		w.cmd = deo_pkg::CMD_W'($urandom_range(CMD_UNUSED_HI, 0));
		w.node = deo_pkg::NODE_W'($urandom);
		w.pin = deo_pkg::PIN_W'($urandom);
		w.source_node = deo_pkg::NODE_W'($urandom);
		w.input_count = deo_pkg::CNT_W'($urandom);
		words.insert(words.size(), w);
	endfunction

	// well-formed graph with occasional open pins, back edges or dropped links
	function automatic void add_graph();
		int nodes[$];
		int cnt[$];
		int k;
		int cand;
		int j;
		bit dup;
		k = ($urandom_range(9, 0) == 0) ? $urandom_range(24, 9) : $urandom_range(8, 1);
		if ($urandom_range(3, 0) != 0) add(deo_pkg::CMD_CLEAR, $urandom_range(63, 0));
		while (nodes.size() < k) begin
			cand = $urandom_range(deo_pkg::NODES - 1, 0);
			dup = 0;
			foreach (nodes[i]) if (nodes[i] == cand) dup = 1;
			if (!dup) nodes.insert(nodes.size(), cand);
		end
		foreach (nodes[i]) begin
			cnt.insert(cnt.size(), i == 0 ? 0 : $urandom_range(3, 1));
			if ($urandom_range(9, 0) == 0 && i > 0) cnt[i] = $urandom_range(deo_pkg::PINS, 4);
			add(deo_pkg::CMD_SET_COUNT, nodes[i], 0, $urandom, cnt[i]);
		end
		foreach (nodes[i]) begin
			for (int p = 0; p < cnt[i]; p++) begin
				j = $urandom_range(i - 1, 0);
				if ($urandom_range(19, 0) == 0) j = $urandom_range(k - 1, i);
				if ($urandom_range(29, 0) != 0) add(deo_pkg::CMD_CONNECT, nodes[i], p, nodes[j]);
			end
		end
		if ($urandom_range(9, 0) == 0)
			add(deo_pkg::CMD_DISCONNECT, nodes[$urandom_range(k - 1, 0)], $urandom_range(2, 0));
		add(deo_pkg::CMD_RUN, nodes[k - 1]);
		if ($urandom_range(3, 0) == 0) add(deo_pkg::CMD_RUN, nodes[$urandom_range(k - 1, 0)]);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		word_t w;
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.cmd <= '0;
			req.node <= '0;
			req.pin <= '0;
			req.source_node <= '0;
			req.input_count <= '0;
		end else if (!req.valid || req.ready) begin
			if (words.size() > 0 && (quiet || $urandom_range(99, 0) >= 31)) begin
				w = words.pop_front();
				req.valid <= 1'b1;
				req.cmd <= w.cmd;
				req.node <= w.node;
				req.pin <= w.pin;
				req.source_node <= w.source_node;
				req.input_count <= w.input_count;
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) res.ready <= 1'b0;
		else res.ready <= !hold_res && (quiet || $urandom_range(99, 0) >= 31);
	end

	always @(posedge clk) begin
		word_t w;
		step_t e;
		cyc <= cyc + 1;
		if (arst_n) begin
			if ((req.valid && req.ready) || (res.valid && res.ready)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG) begin
				$display("[dependency_execution_order] ERROR");
				$finish;
			end
			if (req.valid && req.ready) begin
				w.cmd = req.cmd;
				w.node = req.node;
				w.pin = req.pin;
				w.source_node = req.source_node;
				w.input_count = req.input_count;
				apply_word(w);
			end
			if (res.valid && res.ready) begin
				if (order_exp.size() == 0) begin
					report($sformatf("unexpected word node %0d status %0d", res.order_node,
						res.status));
				end else begin
					e = order_exp.pop_front();
					if (res.order_node !== e.order_node)
						report($sformatf("order_node %0d, want %0d", res.order_node,
							e.order_node));
					if (res.status !== e.status)
						report($sformatf("status %0d, want %0d", res.status, e.status));
					if (res.last !== e.last)
						report($sformatf("last %0d, want %0d", res.last, e.last));
				end
			end
		end
	end

	// hold the result side off while words keep arriving
	initial begin
		repeat (1200) @(posedge clk);
		hold_res = 1'b1;
		repeat (2500) @(posedge clk);
		hold_res = 1'b0;
	end

	initial begin
		foreach (g_total[i]) g_total[i] = '0;
		foreach (g_linked[i]) g_linked[i] = 0;
		foreach (g_src[i]) g_src[i] = '0;
		add(deo_pkg::CMD_RUN, 0);
		add(deo_pkg::CMD_SET_COUNT, 63, 0, 0, 15);
		add(deo_pkg::CMD_RUN, 63);
		add(deo_pkg::CMD_SET_COUNT, 63, 0, 0, 2);
		add(deo_pkg::CMD_CONNECT, 63, 0, 0);
		add(deo_pkg::CMD_CONNECT, 63, 1, 63);
		add(deo_pkg::CMD_RUN, 63);
		add(deo_pkg::CMD_DISCONNECT, 63, 1);
		add(deo_pkg::CMD_DISCONNECT, 63, 1);
		add(deo_pkg::CMD_CONNECT, 63, 1, 5);
		add(deo_pkg::CMD_CONNECT, 63, 1, 7);
		add(deo_pkg::CMD_RUN, 63);
		add(deo_pkg::CMD_SET_COUNT, 5, 0, 0, 8);
		for (int p = 0; p < deo_pkg::PINS; p++) add(deo_pkg::CMD_CONNECT, 5, p, 0);
		add(deo_pkg::CMD_RUN, 63);
		add(CMD_UNUSED_LO, 63, 7, 63, 15);
		add(CMD_UNUSED_HI, 0, 0, 0, 0);
		add(deo_pkg::CMD_CLEAR, 0);
		add(deo_pkg::CMD_RUN, 63);
		while (words.size() < 310) begin
			if ($urandom_range(9, 0) == 0) add_noise();
			else add_graph();
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		while (words.size() > 0 || req.valid || order_exp.size() > 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (errors == 0) $display("[dependency_execution_order] OK");
		else $display("[dependency_execution_order] ERROR");
		$finish;
	end
endmodule

>>> files.f
rtl/core/deo_pkg.sv
rtl/core/deo_if.sv
rtl/core/deo_ram.sv
rtl/core/dependency_execution_order.sv
rtl/core/deo_checker.sv
dv/tb_top.sv
